// ===== hdl/rpfd_pkg.sv =====
// Package: shared types, constants and frame helpers for the PSK frame decoder.
`timescale 1ns / 1ps
package rpfd_pkg;

  localparam int BIT_PERIOD_US = 255;
  localparam int HALF_PERIOD   = BIT_PERIOD_US / 2;
  localparam int QUART_PERIOD  = BIT_PERIOD_US / 4;
  localparam int FRAME_SPAN    = 64;
  localparam int SPAN_LIMIT    = FRAME_SPAN * BIT_PERIOD_US;
  localparam int WIN_W         = 104;
  localparam int PRE_W         = 33;
  localparam int DUR_W         = 16;
  localparam int CARD_W        = 29;
  localparam int PHASE_W       = 8;
  localparam int PHASE_RESET   = 120;
  localparam int NUM_PATHS     = 4;
  localparam int PATH_W        = 2;
  // remainder holds duration + max offset + half period
  localparam int REM_W = $clog2((1 << DUR_W) + (1 << PHASE_W) + HALF_PERIOD);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic PHASE_REG_IDX = 1'b0;

  // preamble: ones at offsets 0, 2 and 32
  localparam logic [PRE_W-1:0] PREAMBLE = 33'h1_0000_0005;

  localparam logic [PATH_W-1:0] LAST_PATH = PATH_W'(NUM_PATHS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PUSH,
    ST_DONE
  } state_e;

  // window bit k is frame bit k; frame bit 0 is the oldest
  function automatic logic frame_ok(input logic [WIN_W-1:0] w);
    return (w[PRE_W-1:0] == PREAMBLE) &&
           (w[FRAME_SPAN +: PRE_W] == PREAMBLE) &&
           !w[60] && !w[61];
  endfunction

  function automatic logic [CARD_W-1:0] extract_card(input logic [WIN_W-1:0] w);
    logic [CARD_W-1:0] c;
    for (int i = 33; i <= 59; i++) begin
      c[CARD_W - 1 - (i - 33)] = w[i];
    end
    c[1] = w[62];
    c[0] = w[63];
    return c;
  endfunction

endpackage

// ===== hdl/rpfd_if.sv =====
// Interfaces: input interval stream and decoded frame result stream.
`timescale 1ns / 1ps
interface rpfd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          level;
  logic [rpfd_pkg::DUR_W-1:0]    duration_us;

  modport source (output valid, level, duration_us, input ready);
  modport sink   (input valid, level, duration_us, output ready);
endinterface

interface rpfd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [rpfd_pkg::CARD_W-1:0]   card_bits;
  logic [rpfd_pkg::PATH_W-1:0]   matched_path;

  modport source (output valid, found, card_bits, matched_path, input ready);
  modport sink   (input valid, found, card_bits, matched_path, output ready);
endinterface

// ===== hdl/rfid_psk_frame_decoder_core.sv =====
// Top level: PSK proximity-card frame decoder, one bit pushed per cycle.
// Each path is checked in ST_LOAD and, when enabled, fed bit by bit in ST_PUSH;
// the result then fills the output register in ST_DONE. One item at a time: the
// next input transfer is taken once the previous result sits in the output register.
// Reset clears control state and the four shift windows and loads PHASE_RESET
// into the phase register.
`timescale 1ns / 1ps
module rfid_psk_frame_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rpfd_in_if.sink                       in_i,
  rpfd_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpfd_pkg::PADDR_W-1:0]  paddr,
  input  logic [rpfd_pkg::PDATA_W-1:0]  pwdata,
  output logic [rpfd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  rpfd_pkg::state_e                  state_q, state_d;
  logic [rpfd_pkg::PATH_W-1:0]       path_q, path_d;
  logic [rpfd_pkg::REM_W-1:0]        rem_q, rem_d;
  logic                              lvl_q, lvl_d;
  logic [rpfd_pkg::DUR_W-1:0]        dur_q, dur_d;
  logic [rpfd_pkg::WIN_W-1:0]        win_q [rpfd_pkg::NUM_PATHS];
  logic [rpfd_pkg::WIN_W-1:0]        win_d [rpfd_pkg::NUM_PATHS];
  logic                              hit_q, hit_d;
  logic [rpfd_pkg::CARD_W-1:0]       card_q, card_d;
  logic [rpfd_pkg::PATH_W-1:0]       mpath_q, mpath_d;
  logic                              ovalid_q, ovalid_d;
  logic                              ofound_q, ofound_d;
  logic [rpfd_pkg::CARD_W-1:0]       ocard_q, ocard_d;
  logic [rpfd_pkg::PATH_W-1:0]       opath_q, opath_d;
  logic [rpfd_pkg::PHASE_W-1:0]      phase_q;

  logic                              cfg_wr;
  logic [rpfd_pkg::REM_W-1:0]        dur_ext, phase_ext, adj_dur, base_dur, rem_load;
  logic                              path_en;
  logic [rpfd_pkg::WIN_W-1:0]        shifted;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[rpfd_pkg::PADDR_W-1] == rpfd_pkg::PHASE_REG_IDX);
  assign prdata = (paddr[rpfd_pkg::PADDR_W-1] == rpfd_pkg::PHASE_REG_IDX) ?
                  rpfd_pkg::PDATA_W'(phase_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rpfd_pkg::PHASE_W'(rpfd_pkg::PHASE_RESET);
    end else if (cfg_wr) begin
      phase_q <= pwdata[rpfd_pkg::PHASE_W-1:0];
    end
  end

  // per-path duration and starting remainder
  assign dur_ext   = rpfd_pkg::REM_W'(dur_q);
  assign phase_ext = rpfd_pkg::REM_W'(phase_q);
  always_comb begin
    if (lvl_q) begin
      adj_dur = dur_ext + phase_ext;
    end else if (dur_ext > phase_ext) begin
      adj_dur = dur_ext - phase_ext;
    end else begin
      adj_dur = dur_ext;
    end
  end
  assign base_dur = path_q[1] ? adj_dur : dur_ext;
  assign path_en  = path_q[1] ? (32'(dur_q) > 32'(rpfd_pkg::QUART_PERIOD)) :
                                (32'(dur_q) > 32'(rpfd_pkg::HALF_PERIOD));
  assign rem_load = base_dur + rpfd_pkg::REM_W'(rpfd_pkg::HALF_PERIOD);

  assign shifted = {lvl_q ^ path_q[0], win_q[path_q][rpfd_pkg::WIN_W-1:1]};

  assign in_i.ready         = (state_q == rpfd_pkg::ST_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.found        = ofound_q;
  assign out_o.card_bits    = ocard_q;
  assign out_o.matched_path = opath_q;

  always_comb begin
    state_d  = state_q;
    path_d   = path_q;
    rem_d    = rem_q;
    lvl_d    = lvl_q;
    dur_d    = dur_q;
    win_d    = win_q;
    hit_d    = hit_q;
    card_d   = card_q;
    mpath_d  = mpath_q;
    ovalid_d = ovalid_q;
    ofound_d = ofound_q;
    ocard_d  = ocard_q;
    opath_d  = opath_q;

    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      rpfd_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          lvl_d   = in_i.level;
          dur_d   = in_i.duration_us;
          path_d  = '0;
          hit_d   = 1'b0;
          card_d  = '0;
          mpath_d = '0;
          state_d = rpfd_pkg::ST_LOAD;
        end
      end
      rpfd_pkg::ST_LOAD: begin
        // a repeat count of FRAME_SPAN or more pushes nothing
        if (path_en && (32'(rem_load) < 32'(rpfd_pkg::SPAN_LIMIT))) begin
          rem_d   = rem_load;
          state_d = rpfd_pkg::ST_PUSH;
        end else if (path_q == rpfd_pkg::LAST_PATH) begin
          state_d = rpfd_pkg::ST_DONE;
        end else begin
          path_d = path_q + 1'b1;
        end
      end
      rpfd_pkg::ST_PUSH: begin
        if (32'(rem_q) >= 32'(rpfd_pkg::BIT_PERIOD_US)) begin
          win_d[path_q] = shifted;
          rem_d = rem_q - rpfd_pkg::REM_W'(rpfd_pkg::BIT_PERIOD_US);
          if (rpfd_pkg::frame_ok(shifted)) begin
            hit_d   = 1'b1;
            card_d  = rpfd_pkg::extract_card(shifted);
            mpath_d = path_q;
            state_d = rpfd_pkg::ST_DONE;
          end
        end else if (path_q == rpfd_pkg::LAST_PATH) begin
          state_d = rpfd_pkg::ST_DONE;
        end else begin
          path_d  = path_q + 1'b1;
          state_d = rpfd_pkg::ST_LOAD;
        end
      end
      rpfd_pkg::ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          ofound_d = hit_q;
          ocard_d  = card_q;
          opath_d  = mpath_q;
          state_d  = rpfd_pkg::ST_IDLE;
        end
      end
      default: state_d = rpfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rpfd_pkg::ST_IDLE;
      path_q   <= '0;
      ovalid_q <= 1'b0;
      hit_q    <= 1'b0;
      for (int p = 0; p < rpfd_pkg::NUM_PATHS; p++) begin
        win_q[p] <= '0;
      end
    end else begin
      state_q  <= state_d;
      path_q   <= path_d;
      ovalid_q <= ovalid_d;
      hit_q    <= hit_d;
      win_q    <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    lvl_q    <= lvl_d;
    dur_q    <= dur_d;
    card_q   <= card_d;
    mpath_q  <= mpath_d;
    ofound_q <= ofound_d;
    ocard_q  <= ocard_d;
    opath_q  <= opath_d;
  end

endmodule
